// ----- sv/afc_pkg.sv -----
// Shared types, widths and helper functions of the box/frustum culling unit.
// Depends on nothing; every other file imports it.
`default_nettype none

package afc_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int MATRIX_WIDTH = 16;
  localparam int COL_WIDTH    = 64;
  localparam int NUM_COLS     = 4;
  localparam int NUM_AXES     = 3;
  localparam int NUM_FACES    = 6;
  localparam int CFG_INDEX_W  = 3;

  // Plane normal and distance need one bit more than a matrix entry.
  localparam int NORM_W = MATRIX_WIDTH + 1;
  localparam int PROD_W = NORM_W + COORD_WIDTH;
  // Three products plus the distance.
  localparam int SUM_W  = PROD_W + 2;

  typedef logic [COL_WIDTH-1:0] col_t;
  typedef col_t [NUM_COLS-1:0]  cols_t;

  // Identity matrix in Q4.12.
  localparam col_t COL0_RESET = 64'h0000_0000_0000_1000;
  localparam col_t COL1_RESET = 64'h0000_0000_1000_0000;
  localparam col_t COL2_RESET = 64'h0000_1000_0000_0000;
  localparam col_t COL3_RESET = 64'h1000_0000_0000_0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COL0 = 3'd0,
    REG_COL1 = 3'd1,
    REG_COL2 = 3'd2,
    REG_COL3 = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_AXES-1:0][NORM_W-1:0] n;
    logic [NORM_W-1:0]               d;
    logic                            zero;
  } plane_t;

  typedef plane_t [NUM_FACES-1:0] planes_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] lo;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] hi;
  } box_t;

  // Entry at a given row of a column; bits past the top of the column read as zero.
  function automatic logic signed [MATRIX_WIDTH-1:0] matrix_entry(col_t col,
                                                                  int unsigned row);
    logic [COL_WIDTH+MATRIX_WIDTH-1:0] ext;
    ext = {{MATRIX_WIDTH{1'b0}}, col} >> (row * MATRIX_WIDTH);
    return ext[MATRIX_WIDTH-1:0];
  endfunction

  // Face f uses row (f >> 1) added to row 3 for even f, subtracted for odd f.
  function automatic plane_t plane_calc(cols_t cols, int unsigned f);
    plane_t                          p;
    int unsigned                     k;
    logic                            neg;
    logic signed [MATRIX_WIDTH-1:0]  a;
    logic signed [MATRIX_WIDTH-1:0]  b;
    logic signed [NORM_W-1:0]        v;
    k   = f >> 1;
    neg = f[0];
    for (int c = 0; c < NUM_COLS; c++) begin
      a = matrix_entry(cols[c], 3);
      b = matrix_entry(cols[c], k);
      v = neg ? (NORM_W'(a) - NORM_W'(b)) : (NORM_W'(a) + NORM_W'(b));
      if (c == NUM_COLS - 1) begin
        p.d = v;
      end else begin
        p.n[c] = v;
      end
    end
    p.zero = (p.n == '0);
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- sv/aabb_frustum_cull.sv -----
// Top level of the box/frustum culling unit: handshake pipeline around the face tests.
// Depends on afc_pkg, afc_planes and afc_face.
`default_nettype none

// Usage
// The input channel (in_valid_i / in_stall_o) carries one box per item: its lower
// and upper corner as signed integers. The output channel (out_valid_o /
// out_stall_i) returns one item per box, visible_o, which is 0 when some frustum
// plane has the whole box on its outer side.
// The configuration channel writes the four view-projection matrix columns
// (index 0 to 3, Q4.12 entries, 16 bits per row); other indexes are ignored.
// cfg_ready_o is always high. Columns must only be written while no box is in
// flight; the planes derived from them are registered after the column registers.
// Timing: an accepted box loads the input register; the face tests work on it
// combinationally and their verdict loads the result register, which offers it
// to the receiver. One box is accepted per cycle while the receiver does not
// stall; the face tests (six planes, three products each) run in parallel.
// When the receiver stalls, the result register holds its item and the input
// register holds the next one; the input side then stalls until the result is
// taken. Reset empties both registers and loads the identity matrix.

module aabb_frustum_cull (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration write channel
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [afc_pkg::CFG_INDEX_W-1:0]         cfg_index_i,
  input  logic [afc_pkg::COL_WIDTH-1:0]           cfg_data_i,
  // Input channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [afc_pkg::COORD_WIDTH-1:0]  box_min_x_i,
  input  logic signed [afc_pkg::COORD_WIDTH-1:0]  box_min_y_i,
  input  logic signed [afc_pkg::COORD_WIDTH-1:0]  box_min_z_i,
  input  logic signed [afc_pkg::COORD_WIDTH-1:0]  box_max_x_i,
  input  logic signed [afc_pkg::COORD_WIDTH-1:0]  box_max_y_i,
  input  logic signed [afc_pkg::COORD_WIDTH-1:0]  box_max_z_i,
  // Output channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    visible_o
);
  import afc_pkg::*;

  planes_t               planes;
  box_t                  box_d;
  box_t                  box_q;
  logic                  in_valid_q;
  logic                  out_valid_q;
  logic                  visible_q;
  logic                  res_free;
  logic                  advance;
  logic                  accept;
  logic [NUM_FACES-1:0]  cull;

  assign cfg_ready_o = 1'b1;

  afc_planes u_planes (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .planes_o    (planes)
  );

  // The result register can take a new item when it is empty or being drained.
  assign res_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && res_free;
  // The input register stalls only when it holds an item that cannot move on.
  assign in_stall_o = in_valid_q && !res_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign box_d.lo = {box_min_z_i, box_min_y_i, box_min_x_i};
  assign box_d.hi = {box_max_z_i, box_max_y_i, box_max_x_i};

  for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
    afc_face u_face (
      .plane_i (planes[f]),
      .box_i   (box_q),
      .cull_o  (cull[f])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      box_q <= box_d;
    end
    if (advance) begin
      visible_q <= ~|cull;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

`ifndef SYNTHESIS
  // An accepted box always occupies the input register in the next cycle.
  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_valid_q)
    else $error("accepted box did not reach the input register");

  // A box that moves on always shows up as a result in the next cycle.
  a_advance_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("box left the input register without a result");

  // The input side stalls only when both registers are full and the output is held.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a full, stalled pipeline");

  // A held box must keep its coordinates while it waits.
  a_box_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(box_q))
    else $error("held box changed while stalled");
`endif

endmodule

`default_nettype wire

// ----- sv/afc_planes.sv -----
// Matrix column registers and the six derived frustum planes, registered.
// Depends on afc_pkg.
`default_nettype none

module afc_planes (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [afc_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [afc_pkg::COL_WIDTH-1:0]     cfg_data_i,
  output afc_pkg::planes_t                  planes_o
);
  import afc_pkg::*;

  cols_t   col_q;
  cols_t   col_d;
  planes_t plane_q;
  planes_t plane_d;
  cols_t   cols_reset;

  assign cols_reset = {COL3_RESET, COL2_RESET, COL1_RESET, COL0_RESET};

  always_comb begin
    col_d = col_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COL0: col_d[0] = cfg_data_i;
        REG_COL1: col_d[1] = cfg_data_i;
        REG_COL2: col_d[2] = cfg_data_i;
        REG_COL3: col_d[3] = cfg_data_i;
        default:  col_d    = col_q;
      endcase
    end
  end

  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      plane_d[f] = plane_calc(col_q, f);
    end
  end

  // Planes follow the columns in the next cycle; the user must write only while idle, unenforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= cols_reset;
      for (int f = 0; f < NUM_FACES; f++) begin
        plane_q[f] <= plane_calc(cols_reset, f);
      end
    end else begin
      col_q   <= col_d;
      plane_q <= plane_d;
    end
  end

  assign planes_o = plane_q;

endmodule

`default_nettype wire

// ----- sv/afc_face.sv -----
// Test of one box against one plane: farthest corner, dot product, sign.
// Depends on afc_pkg.
`default_nettype none

module afc_face (
  input  afc_pkg::plane_t plane_i,
  input  afc_pkg::box_t   box_i,
  output logic            cull_o
);
  import afc_pkg::*;

  logic signed [NORM_W-1:0]      nc   [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] sel  [NUM_AXES];
  logic signed [PROD_W-1:0]      prod [NUM_AXES];
  logic signed [SUM_W-1:0]       sum;

  always_comb begin
    for (int c = 0; c < NUM_AXES; c++) begin
      nc[c] = $signed(plane_i.n[c]);
      // A positive component picks the upper bound; zero or negative the lower.
      sel[c] = (!nc[c][NORM_W-1] && (plane_i.n[c] != '0)) ? $signed(box_i.hi[c])
                                                           : $signed(box_i.lo[c]);
      prod[c] = PROD_W'(nc[c]) * PROD_W'(sel[c]);
    end
    sum = SUM_W'($signed(plane_i.d)) + SUM_W'(prod[0]) + SUM_W'(prod[1])
        + SUM_W'(prod[2]);
  end

  // A plane with an all-zero normal never culls.
  assign cull_o = !plane_i.zero && sum[SUM_W-1];

endmodule

`default_nettype wire

// ----- tb/afc_checker.sv -----
// Checker for the box/frustum culling unit: keeps its own copy of the matrix columns,
// predicts the visible flag of every accepted box and compares it with the result.
// Depends on afc_pkg for widths, types and reset values.

module afc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [afc_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [afc_pkg::COL_WIDTH-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [afc_pkg::COORD_WIDTH-1:0] box_min_x_i,
  input  logic [afc_pkg::COORD_WIDTH-1:0] box_min_y_i,
  input  logic [afc_pkg::COORD_WIDTH-1:0] box_min_z_i,
  input  logic [afc_pkg::COORD_WIDTH-1:0] box_max_x_i,
  input  logic [afc_pkg::COORD_WIDTH-1:0] box_max_y_i,
  input  logic [afc_pkg::COORD_WIDTH-1:0] box_max_z_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            visible_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import afc_pkg::*;

  // Row 3 of the matrix is the w row; column 3 holds the plane distances.
  localparam int W_ROW = 3;
  localparam int D_COL = 3;

  cols_t matrix_q = {COL3_RESET, COL2_RESET, COL1_RESET, COL0_RESET};
  bit    expected_visible_q[$];
  box_t  box;
  bit    want;
  int    failures = 0;

  assign fail_count_o = failures;
  assign pending_o    = expected_visible_q.size();

  // Signed Q4.12 entry at a row of a column; bits beyond the column read as zero.
  function automatic longint entry_of(col_t col, int unsigned row);
    col_t                           shifted;
    logic signed [MATRIX_WIDTH-1:0] e;
    if (row * MATRIX_WIDTH >= COL_WIDTH) return 0;
    shifted = col >> (row * MATRIX_WIDTH);
    e = shifted[MATRIX_WIDTH-1:0];
    return longint'(e);
  endfunction

  // A box is culled when, for some face, even its corner farthest along the normal
  // lies behind the plane. Faces with an all-zero normal never cull.
  function automatic bit box_visible(cols_t m, box_t b);
    longint n [NUM_AXES];
    longint plane_sum;
    longint corner;
    bit     culled;
    culled = 1'b0;
    for (int k = 0; k < NUM_AXES; k++) begin
      for (int s = 1; s >= -1; s -= 2) begin
        for (int c = 0; c < NUM_AXES; c++)
          n[c] = entry_of(m[c], W_ROW) + s * entry_of(m[c], k);
        if (n[0] != 0 || n[1] != 0 || n[2] != 0) begin
          plane_sum = entry_of(m[D_COL], W_ROW) + s * entry_of(m[D_COL], k);
          for (int c = 0; c < NUM_AXES; c++) begin
            corner = (n[c] > 0) ? longint'($signed(b.hi[c])) : longint'($signed(b.lo[c]));
            plane_sum += n[c] * corner;
          end
          if (plane_sum < 0) culled = 1'b1;
        end
      end
    end
    return !culled;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      matrix_q = {COL3_RESET, COL2_RESET, COL1_RESET, COL0_RESET};
      expected_visible_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_visible_q.size() == 0) begin
          $error("visible: no result expected, got %0b", visible_i);
          failures++;
        end else begin
          want = expected_visible_q.pop_front();
          if (visible_i !== want) begin
            $error("visible: expected %0b, got %0b", want, visible_i);
            failures++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NUM_COLS)
        matrix_q[cfg_index_i] = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        box.lo = {box_min_z_i, box_min_y_i, box_min_x_i};
        box.hi = {box_max_z_i, box_max_y_i, box_max_x_i};
        expected_visible_q.push_back(box_visible(matrix_q, box));
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the culling unit testbench: clock, reset, box and matrix stimulus, and the
// verdict. Depends on afc_pkg, the aabb_frustum_cull RTL and afc_checker.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import afc_pkg::*;

  // An index past the four matrix columns; the block must ignore writes to it.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = CFG_INDEX_W'(NUM_COLS + 1);

  localparam int PHASES         = 8;
  localparam int BOXES_PER_PHASE = 250;
  localparam int HOLD_OFF_CYCLES = 300;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [COL_WIDTH-1:0]   cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [COORD_WIDTH-1:0] box_min_x_i, box_min_y_i, box_min_z_i;
  logic [COORD_WIDTH-1:0] box_max_x_i, box_max_y_i, box_max_z_i;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   visible_o;

  int          fail_count;
  int          pending;
  // Idle rates in percent: the sender inserts gaps, the receiver stalls.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  // Long receiver hold-off, requested once by the stimulus and timed by the receiver.
  bit          hold_off_req  = 1'b0;
  bit          hold_off_done = 1'b0;
  int unsigned hold_left     = 0;

  always #5 clk_i = ~clk_i;

  aabb_frustum_cull uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .box_min_x_i (box_min_x_i),
    .box_min_y_i (box_min_y_i),
    .box_min_z_i (box_min_z_i),
    .box_max_x_i (box_max_x_i),
    .box_max_y_i (box_max_y_i),
    .box_max_z_i (box_max_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .visible_o   (visible_o)
  );

  afc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .box_min_x_i  (box_min_x_i),
    .box_min_y_i  (box_min_y_i),
    .box_min_z_i  (box_min_z_i),
    .box_max_x_i  (box_max_x_i),
    .box_max_y_i  (box_max_y_i),
    .box_max_z_i  (box_max_z_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .visible_i    (visible_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver. It stalls at random at the current rate, except during the one long
  // hold-off, when it stalls for a fixed number of cycles so that the result and
  // input registers fill up and the block has to stall its own input.
  always @(negedge clk_i) begin
    if (hold_off_req && !hold_off_done) begin
      hold_off_done = 1'b1;
      hold_left     = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one box and returns at the falling edge after it was taken. Valid stays
  // high on return so that back-to-back boxes keep it high without a glitch; it is
  // only lowered for a gap or when the stream ends.
  task automatic send_box(input int lx, ly, lz, hx, hy, hz);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    box_min_x_i <= COORD_WIDTH'(lx);
    box_min_y_i <= COORD_WIDTH'(ly);
    box_min_z_i <= COORD_WIDTH'(lz);
    box_max_x_i <= COORD_WIDTH'(hx);
    box_max_y_i <= COORD_WIDTH'(hy);
    box_max_z_i <= COORD_WIDTH'(hz);
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Ends the stream and waits until every predicted result has come back, plus a
  // few cycles, so that the matrix can be rewritten with nothing in flight.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all four columns back to back, optionally followed by a write to an
  // unused index, then leaves a few cycles for the derived planes to settle.
  task automatic write_matrix(input cols_t m, input bit junk);
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < NUM_COLS + junk; i++) begin
      if (i == NUM_COLS) begin
        cfg_index_i <= CFG_UNUSED_IDX;
        cfg_data_i  <= {$urandom, $urandom};
      end else begin
        case (i)
          0: cfg_index_i <= REG_COL0;
          1: cfg_index_i <= REG_COL1;
          2: cfg_index_i <= REG_COL2;
          default: cfg_index_i <= REG_COL3;
        endcase
        cfg_data_i <= m[i];
      end
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    repeat (3) @(negedge clk_i);
  endtask

  // Matrix in one of three styles: fully random bits; entries drawn from the
  // extremes (zero, most positive, most negative, plus or minus one) or at random;
  // or the identity with a random translation, which keeps the culling verdict
  // balanced for boxes near the origin.
  function automatic cols_t rand_matrix(int style);
    cols_t m;
    m = {COL3_RESET, COL2_RESET, COL1_RESET, COL0_RESET};
    for (int c = 0; c < NUM_COLS; c++) begin
      for (int r = 0; r < COL_WIDTH / MATRIX_WIDTH; r++) begin
        case (style)
          0: m[c][r*MATRIX_WIDTH +: MATRIX_WIDTH] = MATRIX_WIDTH'($urandom);
          1: begin
            case ($urandom_range(5))
              0: m[c][r*MATRIX_WIDTH +: MATRIX_WIDTH] = '0;
              1: m[c][r*MATRIX_WIDTH +: MATRIX_WIDTH] = 16'h7FFF;
              2: m[c][r*MATRIX_WIDTH +: MATRIX_WIDTH] = 16'h8000;
              3: m[c][r*MATRIX_WIDTH +: MATRIX_WIDTH] = 16'h1000;
              4: m[c][r*MATRIX_WIDTH +: MATRIX_WIDTH] = 16'hF000;
              default: m[c][r*MATRIX_WIDTH +: MATRIX_WIDTH] = MATRIX_WIDTH'($urandom);
            endcase
          end
          default: begin
            if (c == NUM_COLS - 1 && r < NUM_AXES)
              m[c][r*MATRIX_WIDTH +: MATRIX_WIDTH] =
                MATRIX_WIDTH'((int'($urandom_range(14)) - 7) * 4096);
          end
        endcase
      end
    end
    return m;
  endfunction

  // Coordinate within +/- span of the origin, or any 16-bit value for span 0.
  function automatic int rand_coord(int unsigned span);
    if (span == 0) return int'($signed(COORD_WIDTH'($urandom)));
    return int'($urandom_range(2 * span)) - int'(span);
  endfunction

  task automatic send_random_box();
    int unsigned span;
    int          lo [NUM_AXES];
    int          hi [NUM_AXES];
    int          t;
    case ($urandom_range(3))
      0: span = 0;
      1: span = 8;
      2: span = 512;
      default: span = 20000;
    endcase
    for (int c = 0; c < NUM_AXES; c++) begin
      lo[c] = rand_coord(span);
      hi[c] = rand_coord(span);
      // Most boxes are well formed; about one in ten keeps any inversion.
      if (lo[c] > hi[c] && $urandom_range(9) != 0) begin
        t     = lo[c];
        lo[c] = hi[c];
        hi[c] = t;
      end
    end
    send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  // Run limit, far above the slowest correct run.
  initial begin
    #5ms;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    cols_t m;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_COL0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    box_min_x_i = '0;
    box_min_y_i = '0;
    box_min_z_i = '0;
    box_max_x_i = '0;
    box_max_y_i = '0;
    box_max_z_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset matrix is the identity: a box is visible exactly when it touches the
    // cube [-1, 1] on every axis. This covers the boundary where the plane sum is
    // exactly zero, zero normal components, the coordinate extremes and boxes
    // whose min lies above their max.
    send_box(0, 0, 0, 0, 0, 0);
    send_box(-1, -1, -1, -1, -1, -1);
    send_box(-2, -2, -2, -2, -2, -2);
    send_box(2, 0, 0, 5, 0, 0);
    send_box(-32768, -32768, -32768, 32767, 32767, 32767);
    send_box(32767, 32767, 32767, 32767, 32767, 32767);
    send_box(-32768, -32768, -32768, -32768, -32768, -32768);
    send_box(5, 5, 5, -5, -5, -5);
    send_box(1, 1, 1, -1, -1, -1);
    drain();

    // Row 3 equals row 0 in the normal columns, so the negative x face has an
    // all-zero normal with a negative distance: it must not cull anything.
    m = {64'hF000_0000_0000_0000, 64'h0000_1000_0000_0000,
         64'h0000_0000_1000_0000, 64'h1000_0000_0000_1000};
    write_matrix(m, 1'b1);
    send_box(1, 1, 1, 5, 5, 5);
    send_box(-5, -5, -5, 0, 0, 0);
    send_box(-32768, -32768, -32768, 32767, 32767, 32767);
    drain();

    // All-zero matrix: every normal is zero, so every box is visible.
    write_matrix('0, 1'b1);
    send_box(-32768, -32768, -32768, -32768, -32768, -32768);
    send_box(32767, 32767, 32767, -32768, -32768, -32768);
    send_box(3, -7, 11, 4, -6, 12);
    drain();

    // Every entry at the most negative, most positive and minus-one values.
    write_matrix({NUM_COLS{64'h8000_8000_8000_8000}}, 1'b0);
    send_box(-32768, -32768, -32768, 32767, 32767, 32767);
    send_box(32767, 32767, 32767, 32767, 32767, 32767);
    send_box(-32768, -32768, -32768, -32768, -32768, -32768);
    drain();
    write_matrix({NUM_COLS{64'h7FFF_7FFF_7FFF_7FFF}}, 1'b0);
    send_box(-32768, -32768, -32768, 32767, 32767, 32767);
    send_box(-32768, -32768, -32768, -32768, -32768, -32768);
    drain();
    write_matrix({NUM_COLS{64'hFFFF_FFFF_FFFF_FFFF}}, 1'b0);
    send_box(32767, 32767, 32767, 32767, 32767, 32767);
    send_box(-1, -1, -1, 0, 0, 0);
    drain();

    // Random phases. The idle pattern cycles through no idling, a mostly idle
    // sender, a mostly stalling receiver and light idling on both sides; the
    // matrix style cycles independently. One phase with a sender that never
    // pauses also gets the long receiver hold-off.
    for (int p = 0; p < PHASES; p++) begin
      write_matrix(rand_matrix(p % 3), p[0]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 87; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 87; end
        default: begin gap_pct = 31; stall_pct = 31; end
      endcase
      if (p == 4) hold_off_req = 1'b1;
      for (int i = 0; i < BOXES_PER_PHASE; i++) send_random_box();
      drain();
    end

    gap_pct   = 0;
    stall_pct = 0;
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
